// ----- design/lrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Load report line parser package
// Shared types and constants for the line parser: line sizing, the report
// prefix, the parse phases and the load clamp limits.
// ----------------------------------------------------------------------------
package lrlp_pkg;

    // Line storage: a line holds at most LINE_CAPACITY-1 bytes.
    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int LINE_LAST     = LINE_CAPACITY - 1;

    // Report prefix "CPU:".
    localparam int PREFIX_LEN = 4;
    localparam int PFX_IW     = $clog2(PREFIX_LEN);
    localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h43, 8'h50, 8'h55, 8'h3A};

    // Character codes.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Value limits.
    localparam int ACC_W    = 7;
    localparam int ACC_SAT  = 101;
    localparam int LOAD_MAX = 100;

    // Number parsing phase.
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

endpackage

// ----- design/lrlp_if.sv -----
// ----------------------------------------------------------------------------
// Load report line parser channels
// Valid/ready channels for the received byte stream and the load results.
// ----------------------------------------------------------------------------
interface lrlp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lrlp_load_if;
    logic       valid;
    logic       ready;
    logic [6:0] load_percent;

    modport source (output valid, output load_percent, input ready);
    modport sink   (input valid, input load_percent, output ready);
endinterface

// ----- design/load_report_line_parser.sv -----
// ----------------------------------------------------------------------------
// Load report line parser
// Assembles received bytes into lines and reports the load percentage carried
// by lines of the form "CPU:<number>".
// ----------------------------------------------------------------------------
// Usage:
// i_rx carries one received byte per word. Lines end in LF or CR; empty lines
// are ignored and a line longer than LINE_CAPACITY-1 bytes is discarded.
// o_load carries one word, the load percent clamped to 0..100, for every
// non-empty line that starts with "CPU:".
// Throughput is one byte per cycle while i_rx.ready is high: the line state is
// updated by one short combinational step in the cycle a byte is accepted.
// A terminator's result is registered: it goes into the result register if
// that is free or being taken, else into the skid register.
// The output has a result register and a skid register. While the receiver
// stalls, bytes keep flowing until a second result is waiting; only then does
// i_rx.ready drop, and it rises again as soon as o_load takes a word.
// Reset clears the line state and both output valid flags; no memory needs
// clearing, so a byte can be accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module load_report_line_parser (
    input  logic i_clk,
    input  logic i_rst_n,
    lrlp_rx_if.sink     i_rx,
    lrlp_load_if.source o_load
);
    import lrlp_pkg::*;

    // Line state
    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_pm,     n_pm;
    t_phase           r_phase,  n_phase;
    logic             r_neg,    n_neg;
    logic [ACC_W-1:0] r_acc,    n_acc;

    // Output and skid registers
    logic       r_ov, r_sv;
    logic [6:0] r_od, r_sd;

    logic       in_fire, out_take;
    logic [7:0] c;
    logic       is_term, is_blank, is_sign, is_digit;
    logic       emit;
    logic [6:0] res;
    logic [10:0] acc_mul;
    logic [ACC_W-1:0] acc_sat;

    assign c        = i_rx.rx_byte;
    assign in_fire  = i_rx.valid && i_rx.ready;
    assign out_take = r_ov && o_load.ready;

    // Byte classes
    assign is_term  = (c == CH_LF) || (c == CH_CR);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    // Decimal accumulate with saturation at ACC_SAT.
    assign acc_mul = {4'b0, r_acc} * 11'd10 + {7'b0, c[3:0]};
    assign acc_sat = (acc_mul > 11'(ACC_SAT)) ? ACC_W'(ACC_SAT) : acc_mul[ACC_W-1:0];

    // Next line state for an accepted byte.
    always_comb begin
        n_len   = r_len;
        n_pm    = r_pm;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (in_fire) begin
            if (is_term) begin
                if (r_len != '0) begin
                    n_len   = '0;
                    n_pm    = 1'b1;
                    n_phase = PH_SKIP;
                    n_neg   = 1'b0;
                    n_acc   = '0;
                end
            end else if (r_len < LEN_W'(LINE_LAST)) begin
                n_len = r_len + LEN_W'(1);
                if (r_len < LEN_W'(PREFIX_LEN)) begin
                    if (c != PREFIX_TEXT[r_len[PFX_IW-1:0]]) begin
                        n_pm = 1'b0;
                    end
                end else if (r_pm) begin
                    if (c == CH_NUL) begin
                        n_phase = PH_DONE;
                    end else begin
                        unique case (r_phase)
                            PH_SKIP: begin
                                if (is_sign) begin
                                    n_neg   = (c == CH_MINUS);
                                    n_phase = PH_DIGITS;
                                end else if (!is_blank) begin
                                    // Not a sign or a blank: it is read as a digit position.
                                    if (is_digit) begin
                                        n_acc   = acc_sat;
                                        n_phase = PH_DIGITS;
                                    end else begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            end
                            PH_DIGITS: begin
                                if (is_digit) begin
                                    n_acc = acc_sat;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_DONE: begin
                                n_phase = PH_DONE;
                            end
                            default: begin
                                n_phase = PH_DONE;
                            end
                        endcase
                    end
                end
            end else begin
                // Overlong line: drop the byte and start over.
                n_len   = '0;
                n_pm    = 1'b1;
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_acc   = '0;
            end
        end
    end

    // Result for a terminator that ends a matching line.
    always_comb begin
        emit = in_fire && is_term && (r_len >= LEN_W'(PREFIX_LEN)) && r_pm;
        if (r_neg) begin
            res = '0;
        end else if (r_acc > 7'(LOAD_MAX)) begin
            res = 7'(LOAD_MAX);
        end else begin
            res = r_acc;
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pm    <= 1'b1;
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_len   <= n_len;
            r_pm    <= n_pm;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || out_take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= emit;
            end else begin
                r_ov <= emit;
            end
        end else if (emit) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || out_take) begin
            if (r_sv) begin
                r_od <= r_sd;
                r_sd <= res;
            end else begin
                r_od <= res;
            end
        end else if (emit) begin
            r_sd <= res;
        end
    end

    assign i_rx.ready          = !r_sv;
    assign o_load.valid        = r_ov;
    assign o_load.load_percent = r_od;

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register holds a word while the output register is empty");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od <= 7'(LOAD_MAX)))
        else $error("load result above the clamp limit");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_LAST))
        else $error("line length beyond capacity");

    a_term_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_term) |=> (r_len == '0))
        else $error("line not restarted after a terminator");

    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> ((r_acc == '0) && !r_neg))
        else $error("number state set while still skipping blanks");

endmodule
